### design/prc_pkg.sv
// prc_pkg: shared types, constants and a saturation helper for the point/rectangle collision block
// no dependencies
package prc_pkg;

  localparam int unsigned NumRegs = 8;
  localparam int unsigned AddrW = 6;

  // register byte addresses, eight bytes apart
  localparam logic [AddrW-1:0] ADDR_TR_X = 6'd0;
  localparam logic [AddrW-1:0] ADDR_TR_Y = 6'd8;
  localparam logic [AddrW-1:0] ADDR_TR_Z = 6'd16;
  localparam logic [AddrW-1:0] ADDR_BL_X = 6'd24;
  localparam logic [AddrW-1:0] ADDR_BL_Y = 6'd32;
  localparam logic [AddrW-1:0] ADDR_BL_Z = 6'd40;
  localparam logic [AddrW-1:0] ADDR_NORMAL = 6'd48;
  localparam logic [AddrW-1:0] ADDR_FRICTION = 6'd56;

  // 0.0001 in Q0.32
  localparam logic signed [20:0] SurfOffQ32 = 21'sd429497;
  localparam logic [16:0] OneQ16 = 17'd65536;

  typedef struct packed {
    logic signed [31:0] tr_x;
    logic signed [31:0] tr_y;
    logic signed [31:0] tr_z;
    logic signed [31:0] bl_x;
    logic signed [31:0] bl_y;
    logic signed [31:0] bl_z;
    logic signed [15:0] n_x;
    logic signed [15:0] n_y;
    logic signed [15:0] n_z;
    logic [15:0]        friction;
  } cfg_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    logic signed [40:0] hi;
    logic signed [40:0] lo;
    hi = 41'sd2147483647;
    lo = -41'sd2147483648;
    if (v > hi) return 32'sh7fffffff;
    if (v < lo) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

### design/prc_regs.sv
// prc_regs: apb register file for corner, normal and friction settings
// depends on prc_pkg
module prc_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [prc_pkg::AddrW-1:0]    paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready,
  output prc_pkg::cfg_t                cfg
);

  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        prc_pkg::ADDR_TR_X: cfg.tr_x <= pwdata[31:0];
        prc_pkg::ADDR_TR_Y: cfg.tr_y <= pwdata[31:0];
        prc_pkg::ADDR_TR_Z: cfg.tr_z <= pwdata[31:0];
        prc_pkg::ADDR_BL_X: cfg.bl_x <= pwdata[31:0];
        prc_pkg::ADDR_BL_Y: cfg.bl_y <= pwdata[31:0];
        prc_pkg::ADDR_BL_Z: cfg.bl_z <= pwdata[31:0];
        prc_pkg::ADDR_NORMAL: begin
          cfg.n_x <= pwdata[15:0];
          cfg.n_y <= pwdata[31:16];
          cfg.n_z <= pwdata[47:32];
        end
        prc_pkg::ADDR_FRICTION: cfg.friction <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (paddr)
      prc_pkg::ADDR_TR_X: prdata = {{32{cfg.tr_x[31]}}, cfg.tr_x};
      prc_pkg::ADDR_TR_Y: prdata = {{32{cfg.tr_y[31]}}, cfg.tr_y};
      prc_pkg::ADDR_TR_Z: prdata = {{32{cfg.tr_z[31]}}, cfg.tr_z};
      prc_pkg::ADDR_BL_X: prdata = {{32{cfg.bl_x[31]}}, cfg.bl_x};
      prc_pkg::ADDR_BL_Y: prdata = {{32{cfg.bl_y[31]}}, cfg.bl_y};
      prc_pkg::ADDR_BL_Z: prdata = {{32{cfg.bl_z[31]}}, cfg.bl_z};
      prc_pkg::ADDR_NORMAL: prdata = {16'd0, cfg.n_z, cfg.n_y, cfg.n_x};
      prc_pkg::ADDR_FRICTION: prdata = {48'd0, cfg.friction};
      default: prdata = '0;
    endcase
  end

endmodule

### design/prc_pipe.sv
// prc_pipe: eight stage collision datapath with stall-able valid chain and output register
// depends on prc_pkg
module prc_pipe (
  input  logic                clk,
  input  logic                rst,
  input  prc_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [191:0]        in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [95:0]         out_data,
  output logic                out_hit
);

  localparam int unsigned Stages = 8;

  logic [Stages-1:0] vld;
  logic              adv;

  // the whole pipe moves unless the last stage holds an unaccepted result
  assign adv = !vld[Stages-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld[Stages-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Stages-2:0], in_valid};
    end
  end

  // per stage payload
  logic signed [31:0] p1 [3], c1 [3];
  logic signed [32:0] dpv1 [3], dcv1 [3];
  logic signed [48:0] mp2 [3], mc2 [3];
  logic signed [31:0] p2 [3], c2 [3];
  logic signed [50:0] dp3, dc3;
  logic signed [31:0] p3 [3], c3 [3];
  logic               cross4;
  logic signed [36:0] dc16_4;
  logic signed [31:0] p4 [3], c4 [3];
  logic               cross5;
  logic signed [53:0] m5 [3];
  logic signed [31:0] p5 [3], c5 [3];
  logic               cross6;
  logic signed [40:0] tan6 [3];
  logic signed [40:0] corr6 [3];
  logic signed [31:0] p6 [3], c6 [3];
  logic               hit7;
  logic signed [56:0] dn7;
  logic signed [40:0] corr7 [3];
  logic signed [31:0] p7 [3], c7 [3];
  logic signed [31:0] nx [3];
  logic signed [31:0] trv [3], blv [3];

  logic signed [15:0] nv [3];
  assign nv[0] = cfg.n_x;
  assign nv[1] = cfg.n_y;
  assign nv[2] = cfg.n_z;
  assign trv[0] = cfg.tr_x;
  assign trv[1] = cfg.tr_y;
  assign trv[2] = cfg.tr_z;
  assign blv[0] = cfg.bl_x;
  assign blv[1] = cfg.bl_y;
  assign blv[2] = cfg.bl_z;

  // bounds test on projection
  logic inside6;
  always_comb begin
    logic ox, oy, oz;
    ox = tan6[0] > 41'(trv[0]) || tan6[0] < 41'(blv[0]);
    oy = tan6[1] > 41'(trv[1]) || tan6[1] < 41'(blv[1]);
    oz = tan6[2] > 41'(trv[2]) || tan6[2] < 41'(blv[2]);
    if (cfg.tr_x == cfg.bl_x) inside6 = !(oy || oz);
    else if (cfg.tr_y == cfg.bl_y) inside6 = !(ox || oz);
    else inside6 = !(ox || oy);
  end

  logic [16:0] scale;
  assign scale = prc_pkg::OneQ16 - {1'b0, cfg.friction};

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        // s1: offsets from corner
        p1[i] <= in_data[32*i +: 32];
        c1[i] <= in_data[96 + 32*i +: 32];
        dpv1[i] <= 33'(signed'(in_data[32*i +: 32])) - 33'(trv[i]);
        dcv1[i] <= 33'(signed'(in_data[96 + 32*i +: 32])) - 33'(trv[i]);
        // s2: products with normal
        mp2[i] <= dpv1[i] * nv[i];
        mc2[i] <= dcv1[i] * nv[i];
        p2[i] <= p1[i]; c2[i] <= c1[i];
        p3[i] <= p2[i]; c3[i] <= c2[i];
        p4[i] <= p3[i]; c4[i] <= c3[i];
        // s5: normal share of the distance
        m5[i] <= dc16_4 * nv[i];
        p5[i] <= p4[i]; c5[i] <= c4[i];
        // s6: tangent point and correction
        tan6[i] <= 41'(c5[i]) - 41'((m5[i] + 54'sd8192) >>> 14);
        corr6[i] <= 41'(c5[i]) - 41'((m5[i] + 54'sd8192) >>> 14) - 41'(p5[i]);
        p6[i] <= p5[i]; c6[i] <= c5[i];
        corr7[i] <= corr6[i];
        p7[i] <= p6[i]; c7[i] <= c6[i];
      end
      // s3: dot sums
      dp3 <= 51'(mp2[0]) + 51'(mp2[1]) + 51'(mp2[2]);
      dc3 <= 51'(mc2[0]) + 51'(mc2[1]) + 51'(mc2[2]);
      // s4: crossing and rounded distance
      cross4 <= (dp3 > 0) != (dc3 > 0);
      dc16_4 <= 37'((dc3 + 51'sd8192) >>> 14);
      cross5 <= cross4;
      cross6 <= cross5;
      // s7: motion against normal
      hit7 <= cross6 && inside6;
      dn7 <= 57'(corr6[0]) * 57'(nv[0]) + 57'(corr6[1]) * 57'(nv[1]) +
             57'(corr6[2]) * 57'(nv[2]);
    end
  end

  // offset share per axis, constant per configuration
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nx[i] = 32'(((37'(prc_pkg::SurfOffQ32) * 37'(nv[i])) + 37'sd536870912) >>> 30);
    end
  end

  // s8: friction scaling and output register
  logic signed [31:0] outv [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [41:0] cc;
        logic signed [59:0] sc;
        cc = (dn7 > 0) ? 42'(corr7[i]) - 42'(nx[i]) : 42'(corr7[i]) + 42'(nx[i]);
        sc = cc * signed'({1'b0, scale});
        if (hit7)
          outv[i] <= prc_pkg::sat32(41'(p7[i]) + 41'((sc + 60'sd32768) >>> 16));
        else
          outv[i] <= c7[i];
      end
      out_hit <= hit7;
    end
  end

  assign out_data = {outv[2], outv[1], outv[0]};

  // a stalled result holds still
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data) && $stable(out_hit))
    else $error("stalled result changed");
  // with no stall the item count advances by one stage per cycle
  a_move: assert property (@(posedge clk) disable iff (rst)
    adv |=> vld[Stages-1] == $past(vld[Stages-2]))
    else $error("valid chain skipped");
  // no acceptance while the output stalls
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted during stall");

endmodule

### design/point_rectangle_collision_top.sv
// point_rectangle_collision_top: apb registers and the collision pipeline
// depends on prc_pkg, prc_regs, prc_pipe
//
// Takes one point per cycle and returns one result per point, passing it through the eight
// register stages of the datapath (subtract, multiply, sum, round, normal share, tangent,
// bounds and motion dot, friction scale). Output stalls hold the whole pipe; throughput
// stays at one item per cycle while tready is high. The user must write settings over apb
// only while idle; the block itself does not enforce this.
module point_rectangle_collision_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [prc_pkg::AddrW-1:0] paddr,
  input  logic [63:0]               pwdata,
  output logic [63:0]               prdata,
  output logic                      pready,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // prev_x, prev_y, prev_z, cur_x, cur_y, cur_z
  input  logic [191:0]              s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // new_x, new_y, new_z
  output logic [95:0]               m_tdata,
  // hit
  output logic                      m_tuser
);

  prc_pkg::cfg_t cfg;

  prc_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  prc_pipe u_pipe (
    .clk, .rst, .cfg,
    .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata), .out_hit(m_tuser)
  );

endmodule

### tb/point_rectangle_collision_top_tb.sv
// point_rectangle_collision_top_tb: self-checking bench for the point/rectangle collision block
// depends on prc_pkg and point_rectangle_collision_top; predicts each result in fixed point
`timescale 1ns / 100ps

module point_rectangle_collision_top_tb;

  localparam int NumItems = 1750;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic hit;
  } pos_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [prc_pkg::AddrW-1:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic pready;
  logic s_tvalid;
  logic s_tready;
  logic [191:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [95:0] m_tdata;
  logic m_tuser;

  // shadow copy of the register file
  longint tr[3], bl[3], nrm[3], fric;

  pos_t expected_pos[$];
  int mismatches;
  int sent, received, hits;
  bit stall_on;

  point_rectangle_collision_top dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("point_rectangle_collision_top test failed");
    $finish;
  end

  // floor shift with round half up
  function automatic longint rnd_shr(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic pos_t collide(logic [191:0] d);
    pos_t r;
    longint p[3], c[3], tn[3], cr[3];
    longint dp, dc, dc16, dn, scale, off;
    bit in_box;
    dp = 0;
    dc = 0;
    dn = 0;
    for (int i = 0; i < 3; i++) begin
      p[i] = longint'($signed(d[32*i +: 32]));
      c[i] = longint'($signed(d[96 + 32*i +: 32]));
      dp += (p[i] - tr[i]) * nrm[i];
      dc += (c[i] - tr[i]) * nrm[i];
    end
    r.x = c[0][31:0];
    r.y = c[1][31:0];
    r.z = c[2][31:0];
    r.hit = 1'b0;
    if (!((dp > 0 && dc <= 0) || (dp <= 0 && dc > 0))) return r;
    dc16 = rnd_shr(dc, 14);
    for (int i = 0; i < 3; i++) begin
      tn[i] = c[i] - rnd_shr(dc16 * nrm[i], 14);
      cr[i] = tn[i] - p[i];
    end
    // plane chosen by which corner coordinate is degenerate
    if (tr[0] == bl[0])
      in_box = !(tn[1] > tr[1] || tn[1] < bl[1] || tn[2] > tr[2] || tn[2] < bl[2]);
    else if (tr[1] == bl[1])
      in_box = !(tn[0] > tr[0] || tn[0] < bl[0] || tn[2] > tr[2] || tn[2] < bl[2]);
    else
      in_box = !(tn[0] > tr[0] || tn[0] < bl[0] || tn[1] > tr[1] || tn[1] < bl[1]);
    if (!in_box) return r;
    for (int i = 0; i < 3; i++) dn += nrm[i] * cr[i];
    scale = 65536 - fric;
    for (int i = 0; i < 3; i++) begin
      off = rnd_shr(longint'(prc_pkg::SurfOffQ32) * nrm[i], 30);
      cr[i] = (dn > 0) ? cr[i] - off : cr[i] + off;
      c[i] = longint'(clamp32(p[i] + rnd_shr(cr[i] * scale, 16)));
    end
    r.x = c[0][31:0];
    r.y = c[1][31:0];
    r.z = c[2][31:0];
    r.hit = 1'b1;
    return r;
  endfunction

  // apb write, setup then access, then back to idle
  task automatic write_reg(input logic [prc_pkg::AddrW-1:0] addr, input logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr)
      prc_pkg::ADDR_TR_X: tr[0] = longint'($signed(val[31:0]));
      prc_pkg::ADDR_TR_Y: tr[1] = longint'($signed(val[31:0]));
      prc_pkg::ADDR_TR_Z: tr[2] = longint'($signed(val[31:0]));
      prc_pkg::ADDR_BL_X: bl[0] = longint'($signed(val[31:0]));
      prc_pkg::ADDR_BL_Y: bl[1] = longint'($signed(val[31:0]));
      prc_pkg::ADDR_BL_Z: bl[2] = longint'($signed(val[31:0]));
      prc_pkg::ADDR_NORMAL: begin
        nrm[0] = longint'($signed(val[15:0]));
        nrm[1] = longint'($signed(val[31:16]));
        nrm[2] = longint'($signed(val[47:32]));
      end
      prc_pkg::ADDR_FRICTION: fric = longint'(val[15:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [47:0] pack_normal(int nx, int ny, int nz);
    logic [15:0] a, b, c;
    a = nx[15:0];
    b = ny[15:0];
    c = nz[15:0];
    return {c, b, a};
  endfunction

  task automatic set_box(input logic [31:0] trx, try, trz, blx, bly, blz,
                         input logic [47:0] n, input logic [15:0] f);
    write_reg(prc_pkg::ADDR_TR_X, {32'd0, trx});
    write_reg(prc_pkg::ADDR_TR_Y, {32'd0, try});
    write_reg(prc_pkg::ADDR_TR_Z, {32'd0, trz});
    write_reg(prc_pkg::ADDR_BL_X, {32'd0, blx});
    write_reg(prc_pkg::ADDR_BL_Y, {32'd0, bly});
    write_reg(prc_pkg::ADDR_BL_Z, {32'd0, blz});
    write_reg(prc_pkg::ADDR_NORMAL, {16'd0, n});
    write_reg(prc_pkg::ADDR_FRICTION, {48'd0, f});
  endtask

  // one point transfer, with an occasional gap before it; valid stays up between points unless a gap is inserted
  task automatic send_point(input logic [31:0] px, py, pz, cx, cy, cz);
    if ($urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {cz, cy, cx, pz, py, px};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_pos.push_back(collide({cz, cy, cx, pz, py, px}));
    sent++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    while (expected_pos.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (12) @(posedge clk);
  endtask

  // random position near the box, or anywhere
  function automatic logic [31:0] near(longint centre);
    if ($urandom_range(0, 9) == 0) return $urandom;
    return clamp32(centre + $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
  endfunction

  task automatic random_points(input int count);
    longint mx, my, mz;
    logic [31:0] px, py, pz, cx, cy, cz;
    for (int k = 0; k < count; k++) begin
      mx = (tr[0] + bl[0]) / 2;
      my = (tr[1] + bl[1]) / 2;
      mz = (tr[2] + bl[2]) / 2;
      px = near(mx); py = near(my); pz = near(mz);
      cx = near(mx); cy = near(my); cz = near(mz);
      send_point(px, py, pz, cx, cy, cz);
    end
  endtask

  task automatic test_reset_state();
    send_point(32'h0001_0000, 0, 0, 32'hffff_0000, 0, 0);
    send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0);
    drain();
  endtask

  task automatic test_xy_plane();
    // unit normal along z, box in xy
    set_box(32'h0002_0000, 32'h0002_0000, 0, 32'hfffe_0000, 32'hfffe_0000, 0,
            pack_normal(0, 0, 16384), 16'd0);
    send_point(0, 0, 32'h0001_0000, 0, 0, 32'hffff_0000);
    send_point(0, 0, 32'hffff_0000, 0, 0, 32'h0001_0000);
    send_point(32'h0002_0000, 32'hfffe_0000, 32'h0001_0000, 32'h0002_0000,
               32'hfffe_0000, 32'hffff_0000);
    send_point(32'h0003_0000, 0, 32'h0001_0000, 32'h0003_0000, 0, 32'hffff_0000);
    send_point(0, 0, 32'h0001_0000, 0, 0, 0);
    send_point(0, 0, 0, 0, 0, 32'h0001_0000);
    send_point(0, 0, 32'h7fffffff, 0, 0, 32'h80000000);
    drain();
  endtask

  task automatic test_yz_plane();
    set_box(32'h0001_0000, 32'h0004_0000, 32'h0004_0000, 32'h0001_0000, 0, 0,
            pack_normal(-16384, 0, 0), 16'hffff);
    send_point(0, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000);
    send_point(32'h0002_0000, 32'h0001_0000, 32'h0003_0000, 0, 32'h0001_0000, 32'h0003_0000);
    send_point(0, 32'h0005_0000, 0, 32'h0002_0000, 32'h0005_0000, 0);
    drain();
  endtask

  task automatic test_xz_plane();
    // slanted non-unit normal, mid friction
    set_box(32'h0003_0000, 32'hffff_8000, 32'h0003_0000, 32'hfffd_0000, 32'hffff_8000,
            32'hfffd_0000, pack_normal(3000, 12000, -2000), 16'h8000);
    send_point(32'h0000_4000, 0, 0, 32'h0000_4000, 32'hfffe_0000, 32'h0000_1000);
    send_point(0, 32'hfffe_0000, 0, 0, 32'h0001_0000, 0);
    drain();
  endtask

  task automatic test_special_boxes();
    // swapped corners make an empty box
    set_box(32'hffff_0000, 32'hffff_0000, 0, 32'h0001_0000, 32'h0001_0000, 0,
            pack_normal(0, 0, 16384), 16'd1);
    send_point(0, 0, 32'h0001_0000, 0, 0, 32'hffff_0000);
    drain();
    // zero normal never crosses
    write_reg(prc_pkg::ADDR_NORMAL, 64'd0);
    send_point(0, 0, 32'h0001_0000, 0, 0, 32'hffff_0000);
    drain();
    // extreme corners and normal components
    set_box(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
            32'h80000000, pack_normal(-32768, 32767, -32768), 16'hffff);
    send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
               32'h80000000);
    send_point(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
               32'h7fffffff);
    drain();
  endtask

  task automatic test_random_settings(input int rounds, input int per_round);
    logic [31:0] a, b;
    int nx, ny, nz;
    for (int r = 0; r < rounds; r++) begin
      a = $urandom_range(0, 32'h0008_0000);
      b = $urandom_range(0, 32'h0008_0000);
      case ($urandom_range(0, 3))
        0: begin nx = 0; ny = 0; nz = $urandom_range(0, 1) ? 16384 : -16384; end
        1: begin nx = $urandom_range(0, 1) ? 16384 : -16384; ny = 0; nz = 0; end
        2: begin nx = 0; ny = $urandom_range(0, 1) ? 16384 : -16384; nz = 0; end
        default: begin
          nx = $urandom_range(0, 65535) - 32768;
          ny = $urandom_range(0, 65535) - 32768;
          nz = $urandom_range(0, 65535) - 32768;
        end
      endcase
      if (nx != 0 && ny == 0 && nz == 0)
        set_box(a, b, a, a, -b, -a, pack_normal(nx, ny, nz), 16'($urandom));
      else if (ny != 0 && nx == 0 && nz == 0)
        set_box(a, b, a, -a, b, -a, pack_normal(nx, ny, nz), 16'($urandom));
      else if ($urandom_range(0, 7) == 0)
        set_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                pack_normal(nx, ny, nz), 16'($urandom));
      else
        set_box(a, b, b, -a, -b, -b, pack_normal(nx, ny, nz), 16'($urandom));
      random_points(per_round);
      drain();
    end
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_on <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_on <= ~stall_on;
      m_tready <= stall_on ? ($urandom_range(0, 2) == 0) : 1'b1;
    end
  end

  // result checking
  always @(posedge clk) begin
    pos_t exp_p;
    if (!rst && m_tvalid && m_tready) begin
      received++;
      if (m_tuser) hits++;
      if (expected_pos.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer %h", m_tdata);
      end else begin
        exp_p = expected_pos.pop_front();
        if (m_tdata[31:0] !== exp_p.x || m_tdata[63:32] !== exp_p.y ||
            m_tdata[95:64] !== exp_p.z || m_tuser !== exp_p.hit) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h %h %h hit %b, got %h %h %h hit %b",
                     exp_p.x, exp_p.y, exp_p.z, exp_p.hit,
                     m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser);
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    s_tvalid = 1'b0; s_tdata = '0;
    mismatches = 0; sent = 0; received = 0; hits = 0;
    for (int i = 0; i < 3; i++) begin tr[i] = 0; bl[i] = 0; nrm[i] = 0; end
    fric = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_xy_plane();
    test_yz_plane();
    test_xz_plane();
    test_special_boxes();
    test_random_settings(35, NumItems / 35);
    if (expected_pos.size() != 0) begin
      mismatches++;
      $display("%0d results never arrived", expected_pos.size());
    end
    $display("sent %0d points over all three plane orientations, %0d results, %0d hits",
             sent, received, hits);
    if (mismatches == 0)
      $display("point_rectangle_collision_top test passed");
    else
      $display("point_rectangle_collision_top test failed");
    $finish;
  end

endmodule
